/* src/joystick_axis_conditioner_macros.svh */
// assertion macros shared by the conditioner modules
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

// same-cycle implication, held off while reset is low
`define JAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define JAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/jac_pkg.sv */
package jac_pkg;

    // channel count and sample width
    localparam int NUM_CH      = 6;
    localparam int SAMPLE_BITS = 12;
    localparam int CH_W        = $clog2(NUM_CH);

    // register file
    localparam int SCALE_W     = 15;
    localparam int CFG_IDX_W   = $clog2(NUM_CH + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = CFG_IDX_W'(NUM_CH);
    localparam logic [SCALE_W-1:0]   SCALE_RESET = SCALE_W'(1000);

    // filter coefficients, Q0.16
    localparam int Q_W = 16;
    localparam logic [Q_W-1:0] ALPHA_Q16     = 16'd21844;
    localparam logic [Q_W-1:0] ONE_M_ALPHA_Q = 16'd43692;
    localparam int ACC_W = Q_W + SAMPLE_BITS + 1;

    // axis value and bound limits
    localparam int AXIS_W = 16;
    localparam logic signed [AXIS_W-1:0] BOUND_MAX = 16'sh7FFF;
    localparam logic signed [AXIS_W-1:0] BOUND_MIN = -16'sh7FFF;

    // numerator product width
    localparam int PROD_W = 2 * (AXIS_W + 1);

    // divider sizing: two quotient bits per cycle
    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 16;
    localparam int DIV_STEPS = DIV_N_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_ZERO      = 2'd1,
        KIND_CAL_START = 2'd2,
        KIND_CAL_STOP  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EMA,
        S_WB,
        S_MUL,
        S_ABS,
        S_DIV,
        S_FIN,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [SAMPLE_BITS-1:0] sample_ch0;
        logic [SAMPLE_BITS-1:0] sample_ch1;
        logic [SAMPLE_BITS-1:0] sample_ch2;
        logic [SAMPLE_BITS-1:0] sample_ch3;
        logic [SAMPLE_BITS-1:0] sample_ch4;
        logic [SAMPLE_BITS-1:0] sample_ch5;
    } t_in_word;

    typedef struct packed {
        logic signed [AXIS_W-1:0] axis_ch0;
        logic signed [AXIS_W-1:0] axis_ch1;
        logic signed [AXIS_W-1:0] axis_ch2;
        logic signed [AXIS_W-1:0] axis_ch3;
        logic signed [AXIS_W-1:0] axis_ch4;
        logic signed [AXIS_W-1:0] axis_ch5;
        logic                     calibrating;
    } t_out_word;

    // one channel's stored state
    typedef struct packed {
        logic [SAMPLE_BITS-1:0]   level;
        logic signed [AXIS_W-1:0] zero;
        logic signed [AXIS_W-1:0] lo;
        logic signed [AXIS_W-1:0] hi;
    } t_entry;

    // handshake between sequencer and divider
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } t_div_rsp;

endpackage

/* src/jac_div.sv */
`include "joystick_axis_conditioner_macros.svh"

module jac_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jac_pkg::t_div_req  i_req,
    output jac_pkg::t_div_rsp  o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [jac_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [jac_pkg::DIV_D_W-1:0]      r_rem;
    logic [jac_pkg::DIV_N_W-1:0]      r_q;
    logic [jac_pkg::DIV_D_W-1:0]      r_dvs;

    logic [jac_pkg::DIV_D_W:0]        w_t1;
    logic [jac_pkg::DIV_D_W:0]        w_t2;
    logic [jac_pkg::DIV_D_W:0]        w_d1;
    logic [jac_pkg::DIV_D_W:0]        w_d2;
    logic                             w_ge1;
    logic                             w_ge2;
    logic [jac_pkg::DIV_D_W-1:0]      w_rem1;
    logic [jac_pkg::DIV_D_W-1:0]      n_rem;
    logic [jac_pkg::DIV_N_W-1:0]      w_q1;
    logic [jac_pkg::DIV_N_W-1:0]      n_q;
    logic                             w_last;

    // two restoring steps per cycle
    always_comb begin
        w_t1   = {r_rem, r_q[jac_pkg::DIV_N_W-1]};
        w_ge1  = w_t1 >= {1'b0, r_dvs};
        w_d1   = w_t1 - {1'b0, r_dvs};
        w_rem1 = w_ge1 ? w_d1[jac_pkg::DIV_D_W-1:0] : w_t1[jac_pkg::DIV_D_W-1:0];
        w_q1   = {r_q[jac_pkg::DIV_N_W-2:0], w_ge1};
        w_t2   = {w_rem1, w_q1[jac_pkg::DIV_N_W-1]};
        w_ge2  = w_t2 >= {1'b0, r_dvs};
        w_d2   = w_t2 - {1'b0, r_dvs};
        n_rem  = w_ge2 ? w_d2[jac_pkg::DIV_D_W-1:0] : w_t2[jac_pkg::DIV_D_W-1:0];
        n_q    = {w_q1[jac_pkg::DIV_N_W-2:0], w_ge2};
    end

    assign w_last = r_cnt == jac_pkg::DIV_CNT_W'(jac_pkg::DIV_STEPS - 1);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    `JAC_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy, "divider restarted while busy")
    `JAC_ASSERT_IMP(a_done_time, i_clk, i_rst_n, i_req.start, ##(jac_pkg::DIV_STEPS + 1) r_done, "divider done late")
    `JAC_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "divider done held")

endmodule

/* src/joystick_axis_conditioner.sv */
// Six-axis joystick conditioner.
// Input channel: i_in_valid / o_in_stall carry one word of kind plus six
// 12-bit ADC readings. Kind sample updates each axis average (and the bounds
// while calibrating); capture zero, start and stop calibration are commands.
// Every accepted word yields exactly one output word on o_out_valid /
// i_out_stall: six signed 16-bit axis values and the calibrating flag.
// Registers (scale per axis, invert mask) are written on i_cfg_valid /
// o_cfg_ready, which is always ready; write them only while the block is idle.
// Sequencing: one word is handled axis by axis; each axis passes through read,
// filter, write back, multiply, magnitude, the divider and finish, or goes
// from multiply straight to finish when its divisor is zero. The shared
// divider retires two quotient bits a cycle. A new word is taken as soon as the
// result has moved to the output register, even if the receiver still stalls
// it; a stalled result simply holds and the next result waits behind it.
// Reset: averages and offsets read as zero, bounds as +/-32767, scales 1000,
// invert mask clear, calibration off, no output pending.
`include "joystick_axis_conditioner_macros.svh"

module joystick_axis_conditioner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  jac_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output jac_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jac_pkg::SCALE_W-1:0]         i_cfg_data
);

    jac_pkg::t_state                      r_st;
    jac_pkg::t_state                      n_st;
    logic [jac_pkg::CH_W-1:0]             r_ch;
    jac_pkg::t_kind                       r_kind;
    logic [jac_pkg::SAMPLE_BITS-1:0]      r_smp [jac_pkg::NUM_CH];
    logic                                 r_calib;
    logic [jac_pkg::SCALE_W-1:0]          r_scale [jac_pkg::NUM_CH];
    logic [jac_pkg::NUM_CH-1:0]           r_inv;

    // channel state memory and its valid bits
    jac_pkg::t_entry                      r_mem [jac_pkg::NUM_CH];
    logic [jac_pkg::NUM_CH-1:0]           r_vld;
    jac_pkg::t_entry                      r_rd;
    logic                                 r_rd_vld;

    jac_pkg::t_entry                      r_ent;
    logic signed [jac_pkg::AXIS_W-1:0]    r_v;
    logic signed [jac_pkg::DIV_N_W-1:0]   r_num;
    logic signed [jac_pkg::AXIS_W:0]      r_den;
    logic                                 r_pos;
    logic                                 r_dz;
    logic                                 r_qneg;
    logic signed [jac_pkg::AXIS_W-1:0]    r_axis [jac_pkg::NUM_CH];
    logic                                 r_out_vld;
    jac_pkg::t_out_word                   r_out;

    logic                                 w_accept;
    logic                                 w_we;
    logic                                 w_out_load;
    logic                                 w_last_ch;
    logic                                 w_div_start;
    logic [jac_pkg::DIV_N_W-1:0]          w_div_dividend;
    logic [jac_pkg::DIV_D_W-1:0]          w_div_divisor;
    jac_pkg::t_div_req                    w_div_req;
    jac_pkg::t_div_rsp                    w_div_rsp;

    jac_pkg::t_entry                      w_old;
    jac_pkg::t_entry                      w_ema_ent;
    jac_pkg::t_entry                      w_wb_ent;
    logic [jac_pkg::ACC_W-1:0]            w_acc;
    logic [jac_pkg::AXIS_W-1:0]           w_neg_lvl;
    logic signed [jac_pkg::AXIS_W-1:0]    w_v;
    logic [jac_pkg::SCALE_W-1:0]          w_s;
    logic signed [jac_pkg::AXIS_W-1:0]    w_s16;
    logic signed [jac_pkg::AXIS_W:0]      w_mop;
    logic signed [jac_pkg::PROD_W-1:0]    w_prod;
    logic signed [jac_pkg::AXIS_W:0]      w_den_neg;
    logic signed [jac_pkg::DIV_N_W-1:0]   w_num_neg;
    logic [jac_pkg::DIV_N_W-1:0]          w_quot_neg;
    logic [jac_pkg::DIV_N_W-1:0]          w_q;
    logic signed [jac_pkg::AXIS_W-1:0]    w_q16;
    logic signed [jac_pkg::AXIS_W-1:0]    w_rp;
    logic signed [jac_pkg::AXIS_W-1:0]    w_t;
    logic signed [jac_pkg::AXIS_W-1:0]    w_rn;
    logic signed [jac_pkg::AXIS_W-1:0]    w_r;
    logic signed [jac_pkg::AXIS_W-1:0]    w_axis;

    assign w_last_ch = r_ch == jac_pkg::CH_W'(jac_pkg::NUM_CH - 1);
    assign w_accept  = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            jac_pkg::S_IDLE: if (i_in_valid) n_st = jac_pkg::S_RD;
            jac_pkg::S_RD:   n_st = jac_pkg::S_EMA;
            jac_pkg::S_EMA:  n_st = jac_pkg::S_WB;
            jac_pkg::S_WB:   n_st = jac_pkg::S_MUL;
            jac_pkg::S_MUL:  n_st = (r_pos ? r_ent.hi == '0 : r_ent.lo == '0) ?
                                    jac_pkg::S_FIN : jac_pkg::S_ABS;
            jac_pkg::S_ABS:  n_st = jac_pkg::S_DIV;
            jac_pkg::S_DIV:  if (w_div_rsp.done) n_st = jac_pkg::S_FIN;
            jac_pkg::S_FIN:  n_st = w_last_ch ? jac_pkg::S_PUSH : jac_pkg::S_RD;
            jac_pkg::S_PUSH: if (!r_out_vld || !i_out_stall) n_st = jac_pkg::S_IDLE;
            default:         n_st = jac_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_we        = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_st)
            jac_pkg::S_IDLE: o_in_stall = 1'b0;
            jac_pkg::S_WB:   w_we = 1'b1;
            jac_pkg::S_ABS:  w_div_start = 1'b1;
            jac_pkg::S_PUSH: w_out_load = !r_out_vld || !i_out_stall;
            jac_pkg::S_RD, jac_pkg::S_EMA, jac_pkg::S_MUL,
            jac_pkg::S_DIV, jac_pkg::S_FIN: o_in_stall = 1'b1;
            default:         o_in_stall = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= jac_pkg::S_IDLE;
            r_ch      <= '0;
            r_calib   <= 1'b0;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_accept) begin
                r_ch <= '0;
                if (i_in_word.kind == jac_pkg::KIND_CAL_START) begin
                    r_calib <= 1'b1;
                end else if (i_in_word.kind == jac_pkg::KIND_CAL_STOP) begin
                    r_calib <= 1'b0;
                end
            end else if (r_st == jac_pkg::S_FIN && !w_last_ch) begin
                r_ch <= r_ch + 1'b1;
            end
            if (w_we) begin
                r_vld[r_ch] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < jac_pkg::NUM_CH; i++) begin
                r_scale[i] <= jac_pkg::SCALE_RESET;
            end
            r_inv <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index < jac_pkg::CFG_INVERT) begin
                r_scale[i_cfg_index[jac_pkg::CH_W-1:0]] <= i_cfg_data;
            end else if (i_cfg_index == jac_pkg::CFG_INVERT) begin
                r_inv <= i_cfg_data[jac_pkg::NUM_CH-1:0];
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // capture input word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_in_word.kind;
            r_smp[0] <= i_in_word.sample_ch0;
            r_smp[1] <= i_in_word.sample_ch1;
            r_smp[2] <= i_in_word.sample_ch2;
            r_smp[3] <= i_in_word.sample_ch3;
            r_smp[4] <= i_in_word.sample_ch4;
            r_smp[5] <= i_in_word.sample_ch5;
        end
    end

    // state memory: registered read, write in writeback
    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[r_ch];
        r_rd_vld <= r_vld[r_ch];
        if (w_we) begin
            r_mem[r_ch] <= w_wb_ent;
        end
    end

    // unwritten entries read as their reset value
    always_comb begin
        if (r_rd_vld) begin
            w_old = r_rd;
        end else begin
            w_old.level = '0;
            w_old.zero  = '0;
            w_old.lo    = jac_pkg::BOUND_MAX;
            w_old.hi    = jac_pkg::BOUND_MIN;
        end
    end

    // filter update and commands
    always_comb begin
        w_acc = jac_pkg::ACC_W'(jac_pkg::ALPHA_Q16) * jac_pkg::ACC_W'(r_smp[r_ch])
              + jac_pkg::ACC_W'(jac_pkg::ONE_M_ALPHA_Q) * jac_pkg::ACC_W'(w_old.level);
        w_neg_lvl = -jac_pkg::AXIS_W'(w_old.level);
        w_ema_ent = w_old;
        case (r_kind)
            jac_pkg::KIND_SAMPLE:
                w_ema_ent.level = w_acc[jac_pkg::Q_W +: jac_pkg::SAMPLE_BITS];
            jac_pkg::KIND_ZERO:
                w_ema_ent.zero = w_neg_lvl;
            jac_pkg::KIND_CAL_START: begin
                w_ema_ent.lo = jac_pkg::BOUND_MAX;
                w_ema_ent.hi = jac_pkg::BOUND_MIN;
            end
            default: w_ema_ent = w_old;
        endcase
    end

    // offset level and bound tracking
    always_comb begin
        w_v      = $signed(jac_pkg::AXIS_W'(r_ent.level)) + r_ent.zero;
        w_wb_ent = r_ent;
        if (r_kind == jac_pkg::KIND_SAMPLE && r_calib) begin
            if (w_v < r_ent.lo) begin
                w_wb_ent.lo = w_v;
            end else if (w_v > r_ent.hi) begin
                w_wb_ent.hi = w_v;
            end
        end
    end

    // scale and numerator product
    always_comb begin
        w_s   = r_scale[r_ch];
        w_s16 = $signed({1'b0, w_s});
        w_mop = r_pos ? (jac_pkg::AXIS_W + 1)'(r_v)
                      : (jac_pkg::AXIS_W + 1)'(r_v) - (jac_pkg::AXIS_W + 1)'(r_ent.lo);
        w_prod = jac_pkg::PROD_W'(w_mop) * jac_pkg::PROD_W'($signed({2'b00, w_s}));
    end

    // magnitudes for the unsigned divider
    always_comb begin
        w_den_neg      = -r_den;
        w_num_neg      = -r_num;
        w_div_dividend = r_num[jac_pkg::DIV_N_W-1] ? w_num_neg : r_num;
        w_div_divisor  = r_den[jac_pkg::AXIS_W] ? w_den_neg[jac_pkg::DIV_D_W-1:0]
                                                : r_den[jac_pkg::DIV_D_W-1:0];
    end

    assign w_div_req = {w_div_start, w_div_dividend, w_div_divisor};

    jac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // signed quotient, offset, clamp, invert
    always_comb begin
        w_quot_neg = -w_div_rsp.quot;
        w_q        = r_qneg ? w_quot_neg : w_div_rsp.quot;
        w_q16      = $signed(w_q[jac_pkg::AXIS_W-1:0]);
        w_rp       = (w_q16 > w_s16) ? w_s16 : w_q16;
        w_t        = w_q16 - w_s16;
        w_rn       = (w_t < -w_s16) ? -w_s16 : w_t;
        if (r_dz) begin
            w_r = '0;
        end else if (r_pos) begin
            w_r = w_rp;
        end else begin
            w_r = w_rn;
        end
        w_axis = r_inv[r_ch] ? -w_r : w_r;
    end

    // per-axis datapath registers
    always_ff @(posedge i_clk) begin
        case (r_st)
            jac_pkg::S_EMA: r_ent <= w_ema_ent;
            jac_pkg::S_WB: begin
                r_ent <= w_wb_ent;
                r_v   <= w_v;
                r_pos <= w_v > 0;
            end
            jac_pkg::S_MUL: begin
                r_num <= w_prod[jac_pkg::DIV_N_W-1:0];
                r_den <= r_pos ? (jac_pkg::AXIS_W + 1)'(r_ent.hi)
                               : -(jac_pkg::AXIS_W + 1)'(r_ent.lo);
                r_dz  <= r_pos ? r_ent.hi == '0 : r_ent.lo == '0;
            end
            jac_pkg::S_ABS: r_qneg <= r_num[jac_pkg::DIV_N_W-1] ^ r_den[jac_pkg::AXIS_W];
            jac_pkg::S_FIN: r_axis[r_ch] <= w_axis;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.axis_ch0    <= r_axis[0];
            r_out.axis_ch1    <= r_axis[1];
            r_out.axis_ch2    <= r_axis[2];
            r_out.axis_ch3    <= r_axis[3];
            r_out.axis_ch4    <= r_axis[4];
            r_out.axis_ch5    <= r_axis[5];
            r_out.calibrating <= r_calib;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    `JAC_ASSERT_NXT(a_accept_start, i_clk, i_rst_n, w_accept, r_st == jac_pkg::S_RD && r_ch == '0, "accepted word did not start at axis zero")
    `JAC_ASSERT_NXT(a_push_hold, i_clk, i_rst_n, r_st == jac_pkg::S_PUSH && r_out_vld && i_out_stall, r_st == jac_pkg::S_PUSH, "result pushed over a stalled word")
    `JAC_ASSERT_NXT(a_push_flag, i_clk, i_rst_n, w_out_load, o_out_valid && o_out_word.calibrating == $past(r_calib), "calibrating flag lost on push")
    `JAC_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, w_div_rsp.done, r_st == jac_pkg::S_DIV, "divider finished outside its wait state")

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
    import jac_pkg::*;

    // filter weights, Q0.16
    localparam int unsigned EMA_NEW = 21844;
    localparam int unsigned EMA_OLD = 43692;

    // bound values after start of calibration
    localparam logic signed [AXIS_W-1:0] LO_START = 16'sh7FFF;
    localparam logic signed [AXIS_W-1:0] HI_START = -16'sh7FFF;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_SCALE0 = '0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = '1;
    localparam logic [SCALE_W-1:0]   SCALE_TOP  = '1;
    localparam logic [SCALE_W-1:0]   SCALE_DEF  = 15'd1000;

    localparam int SW              = NUM_CH * SAMPLE_BITS;
    localparam int WORDS_PER_PHASE = 300;
    localparam int HOLD_LEN        = 600;
    localparam int QUIET_LIMIT     = 5000;
    localparam int SETTLE          = 150;
    localparam int MAX_REPORTS     = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SCALE_W-1:0]   i_cfg_data  = '0;

    joystick_axis_conditioner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // conditioner state as the testbench sees it
    logic [SAMPLE_BITS-1:0]   avg_level [NUM_CH];
    logic signed [AXIS_W-1:0] zero_ofs  [NUM_CH];
    logic signed [AXIS_W-1:0] bound_lo  [NUM_CH];
    logic signed [AXIS_W-1:0] bound_hi  [NUM_CH];
    logic                     cal_on;
    logic [SCALE_W-1:0]       scale_m   [NUM_CH];
    logic [NUM_CH-1:0]        invert_m;

    // expected output words, oldest first
    t_out_word pending_axes[$];

    logic idle_on      = 1'b0;
    int   hold_ticket  = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   fail_count   = 0;
    int   words_sent   = 0;

    function automatic void reset_model();
        for (int ch = 0; ch < NUM_CH; ch++) begin
            avg_level[ch] = '0;
            zero_ofs[ch]  = '0;
            bound_lo[ch]  = LO_START;
            bound_hi[ch]  = HI_START;
            scale_m[ch]   = SCALE_DEF;
        end
        cal_on   = 1'b0;
        invert_m = '0;
    endfunction

    function automatic logic signed [AXIS_W-1:0] wrap_axis(input longint x);
        return x[AXIS_W-1:0];
    endfunction

    function automatic logic signed [AXIS_W-1:0] offset_level(input int ch);
        return wrap_axis(longint'(avg_level[ch]) + longint'(zero_ofs[ch]));
    endfunction

    // piecewise-linear map of one axis onto +/- scale
    function automatic logic signed [AXIS_W-1:0] map_axis(input int ch);
        longint s, v, d, r;
        s = scale_m[ch];
        v = offset_level(ch);
        if (v > 0) begin
            d = bound_hi[ch];
            if (d == 0) return '0;
            r = wrap_axis((v * s) / d);
            if (r > s) r = s;
        end else begin
            d = -longint'(bound_lo[ch]);
            if (d == 0) return '0;
            r = wrap_axis(((v - bound_lo[ch]) * s) / d - s);
            if (r < -s) r = -s;
        end
        if (invert_m[ch]) r = wrap_axis(-r);
        return wrap_axis(r);
    endfunction

    // apply one input word to the state and build the output word it yields
    function automatic t_out_word condition_word(input t_in_word w);
        logic [SW-1:0]            smp;
        logic [NUM_CH*AXIS_W-1:0] axes;
        logic signed [AXIS_W-1:0] lvl;
        logic [31:0]              acc;
        smp = w[SW-1:0];
        case (w.kind)
            KIND_SAMPLE: begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    acc = EMA_NEW * smp[(NUM_CH-1-ch)*SAMPLE_BITS +: SAMPLE_BITS]
                        + EMA_OLD * avg_level[ch];
                    avg_level[ch] = acc[16 +: SAMPLE_BITS];
                    if (cal_on) begin
                        lvl = offset_level(ch);
                        if (lvl < bound_lo[ch]) bound_lo[ch] = lvl;
                        else if (lvl > bound_hi[ch]) bound_hi[ch] = lvl;
                    end
                end
            end
            KIND_ZERO: begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    zero_ofs[ch] = wrap_axis(-longint'(avg_level[ch]));
            end
            KIND_CAL_START: begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    bound_lo[ch] = LO_START;
                    bound_hi[ch] = HI_START;
                end
                cal_on = 1'b1;
            end
            default: begin
                cal_on = 1'b0;
            end
        endcase
        for (int ch = 0; ch < NUM_CH; ch++)
            axes[(NUM_CH-1-ch)*AXIS_W +: AXIS_W] = map_axis(ch);
        return t_out_word'({axes, cal_on});
    endfunction

    function automatic t_in_word make_word(input t_kind k, input logic [SW-1:0] smp);
        return t_in_word'({k, smp});
    endfunction

    // random readings with the rails mixed in
    function automatic logic [SW-1:0] random_samples(input int lo_v, input int hi_v);
        logic [SW-1:0] smp;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            case ($urandom_range(0, 9))
                0:       smp[ch*SAMPLE_BITS +: SAMPLE_BITS] = '0;
                1:       smp[ch*SAMPLE_BITS +: SAMPLE_BITS] = '1;
                default: smp[ch*SAMPLE_BITS +: SAMPLE_BITS] =
                             SAMPLE_BITS'($urandom_range(lo_v, hi_v));
            endcase
        end
        return smp;
    endfunction

    function automatic logic [NUM_CH*SCALE_W-1:0] random_scales();
        logic [NUM_CH*SCALE_W-1:0] sc;
        for (int ch = 0; ch < NUM_CH; ch++)
            sc[ch*SCALE_W +: SCALE_W] = SCALE_W'($urandom_range(0, 32767));
        return sc;
    endfunction

    function automatic void flag_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    // register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_CH) scale_m[idx] = val;
        else if (idx == CFG_INVERT) invert_m = val[NUM_CH-1:0];
    endtask

    task automatic load_config(input logic [NUM_CH*SCALE_W-1:0] scales,
                               input logic [NUM_CH-1:0] inv);
        for (int ch = 0; ch < NUM_CH; ch++)
            write_reg(REG_SCALE0 + CFG_IDX_W'(ch), scales[ch*SCALE_W +: SCALE_W]);
        write_reg(CFG_INVERT, SCALE_W'(inv));
        i_cfg_valid <= 1'b0;
    endtask

    // offer one word, with an occasional gap in front, and predict its output
    task automatic send_word(input t_in_word w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        pending_axes.push_back(condition_word(w));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_axes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // zero, calibrate, sweep, then use; the rest is noise
    task automatic run_random_phase(input int words);
        int start;
        start = words_sent;
        while (words_sent - start < words) begin
            if ($urandom_range(0, 9) < 6) begin
                repeat ($urandom_range(2, 6))
                    send_word(make_word(KIND_SAMPLE, random_samples(1800, 2300)));
                send_word(make_word(KIND_ZERO, random_samples(0, 4095)));
                send_word(make_word(KIND_CAL_START, random_samples(0, 4095)));
                repeat ($urandom_range(4, 20))
                    send_word(make_word(KIND_SAMPLE, random_samples(0, 4095)));
                send_word(make_word(KIND_CAL_STOP, random_samples(0, 4095)));
                repeat ($urandom_range(4, 20))
                    send_word(make_word(KIND_SAMPLE, random_samples(0, 4095)));
            end else begin
                repeat ($urandom_range(1, 10))
                    send_word(make_word(t_kind'($urandom_range(0, 3)),
                                        random_samples(0, 4095)));
            end
        end
    endtask

    // quotient wraps to the most negative value, then negation keeps it there
    task automatic test_wrap_negate();
        write_reg(REG_SPARE, SCALE_TOP);
        load_config({NUM_CH{15'd16384}}, '1);
        send_word(make_word(KIND_CAL_START, '1));
        send_word(make_word(KIND_SAMPLE, {NUM_CH{12'd4}}));
        send_word(make_word(KIND_SAMPLE, {NUM_CH{12'd4}}));
        send_word(make_word(KIND_CAL_STOP, '0));
        send_word(make_word(KIND_SAMPLE, {NUM_CH{12'd5}}));
        wait_drain();
    endtask

    // bounds collapse to zero on both sides of the offset level
    task automatic test_zero_divisor();
        load_config({15'd12345, SCALE_TOP, SCALE_DEF, 15'd1, SCALE_TOP, 15'd0}, 6'b101010);
        send_word(make_word(KIND_ZERO, '0));
        send_word(make_word(KIND_CAL_START, '0));
        send_word(make_word(KIND_SAMPLE, {NUM_CH{12'd5}}));
        send_word(make_word(KIND_SAMPLE, {NUM_CH{12'd5}}));
        send_word(make_word(KIND_CAL_STOP, '0));
        send_word(make_word(KIND_SAMPLE, '1));
        send_word(make_word(KIND_ZERO, '0));
        send_word(make_word(KIND_SAMPLE, '0));
        wait_drain();
    endtask

    // rails, bit patterns and every kind
    task automatic test_field_extremes();
        load_config({NUM_CH{SCALE_TOP}}, 6'b010101);
        send_word(make_word(KIND_SAMPLE, '1));
        send_word(make_word(KIND_SAMPLE, '0));
        send_word(make_word(KIND_SAMPLE, {NUM_CH/2{12'hAAA, 12'h555}}));
        send_word(make_word(KIND_SAMPLE, {NUM_CH/2{12'h555, 12'hAAA}}));
        send_word(make_word(KIND_CAL_START, '1));
        send_word(make_word(KIND_SAMPLE, '1));
        send_word(make_word(KIND_SAMPLE, '0));
        send_word(make_word(KIND_CAL_STOP, '1));
        send_word(make_word(KIND_ZERO, '1));
        send_word(make_word(KIND_SAMPLE, '1));
        wait_drain();
    endtask

    task automatic test_random_settings();
        load_config({NUM_CH{SCALE_TOP}}, '1);
        run_random_phase(WORDS_PER_PHASE);
        wait_drain();
        load_config('0, '0);
        run_random_phase(WORDS_PER_PHASE);
        wait_drain();
        idle_on <= 1'b0;
        load_config(random_scales(), NUM_CH'($urandom));
        run_random_phase(WORDS_PER_PHASE);
        wait_drain();
        idle_on <= 1'b1;
        load_config({NUM_CH{15'd1}}, 6'b010101);
        run_random_phase(WORDS_PER_PHASE);
        wait_drain();
    endtask

    // receiver holds off long enough for the input side to back up
    task automatic test_backpressure();
        load_config(random_scales(), NUM_CH'($urandom));
        hold_ticket <= hold_ticket + 1;
        run_random_phase(WORDS_PER_PHASE);
        wait_drain();
    endtask

    task automatic test_steady_stream();
        idle_on <= 1'b0;
        load_config({NUM_CH{SCALE_DEF}}, NUM_CH'($urandom));
        run_random_phase(WORDS_PER_PHASE);
        wait_drain();
    endtask

    // output stall: long hold on request, else random bursts
    always @(posedge i_clk) begin
        if (hold_seen != hold_ticket) begin
            hold_seen   <= hold_ticket;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // output check against the oldest expected word
    always @(posedge i_clk) begin
        t_out_word                want;
        logic signed [AXIS_W-1:0] want_axis;
        logic signed [AXIS_W-1:0] got_axis;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_axes.size() == 0) begin
                flag_error("output word with none expected");
            end else begin
                want = pending_axes.pop_front();
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    want_axis = want[1 + (NUM_CH-1-ch)*AXIS_W +: AXIS_W];
                    got_axis  = o_out_word[1 + (NUM_CH-1-ch)*AXIS_W +: AXIS_W];
                    if (got_axis !== want_axis)
                        flag_error($sformatf("axis %0d expected %0d got %0d",
                                             ch, want_axis, got_axis));
                end
                if (o_out_word.calibrating !== want.calibrating)
                    flag_error($sformatf("calibrating expected %0b got %0b",
                                         want.calibrating, o_out_word.calibrating));
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("joystick_axis_conditioner regression: fail");
            $finish;
        end
    end

    // test sequence
    initial begin
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;
        @(posedge i_clk);
        test_wrap_negate();
        test_zero_divisor();
        test_field_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        wait_drain();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending_axes.size() == 0) begin
            $display("joystick_axis_conditioner regression: pass");
        end else begin
            $display("joystick_axis_conditioner regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/jac_pkg.sv
src/jac_div.sv
src/joystick_axis_conditioner.sv
test/tb.sv
